### hdl/rbpa_pkg.sv
// Shared types, constants and the region layout function of the page frame allocator.
package rbpa_pkg;

   localparam int MAX_FRAMES  = 4096;
   localparam int NUM_REGIONS = 3;
   localparam int PAGE_SHIFT  = 12;
   localparam int FRAME_W     = $clog2(MAX_FRAMES);
   localparam int PAGES_W     = 13;
   localparam int BASE_W      = 36;
   localparam int ADDR_W      = 48;
   localparam int MAP_BYTES   = MAX_FRAMES / 8;
   localparam int BYTE_IDX_W  = $clog2(MAP_BYTES);
   localparam int BYTE_CNT_W  = BYTE_IDX_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 36;

   localparam logic [PAGES_W-1:0] FRAME_CAP = PAGES_W'(MAX_FRAMES);

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_R0_BASE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_R0_PAGES     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_R1_BASE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_R1_PAGES     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_R2_BASE      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_R2_PAGES     = 3'd6;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [1:0] STATUS_NO_REGION = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] page_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] frame_address;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [PAGES_W-1:0] eff0;
      logic [PAGES_W-1:0] eff1;
      logic [PAGES_W-1:0] eff2;
      logic [PAGES_W-1:0] end0;
      logic [PAGES_W-1:0] end1;
      logic [PAGES_W-1:0] total;
   } layout_type;

   // Regions sit end to end in frame index space, each clipped to what fits under the cap.
   function automatic layout_type calc_layout(input logic [1:0] count,
                                              input logic [PAGES_W-1:0] p0,
                                              input logic [PAGES_W-1:0] p1,
                                              input logic [PAGES_W-1:0] p2);
      layout_type         lay;
      logic [PAGES_W-1:0] room;
      lay  = '0;
      room = FRAME_CAP;
      if (count >= 2'd1) begin
         lay.eff0 = (p0 > room) ? room : p0;
      end
      lay.end0 = lay.eff0;
      room     = FRAME_CAP - lay.end0;
      if (count >= 2'd2) begin
         lay.eff1 = (p1 > room) ? room : p1;
      end
      lay.end1 = lay.end0 + lay.eff1;
      room     = FRAME_CAP - lay.end1;
      if (count >= 2'd3) begin
         lay.eff2 = (p2 > room) ? room : p2;
      end
      lay.total = lay.end1 + lay.eff2;
      return lay;
   endfunction

endpackage

### hdl/region_bitmap_page_allocator_core.sv
// Top level of the page frame allocator: bitmap memory, region registers and sequencer.
//
// One word in, one result word out. After reset the block clears every byte of the bitmap
// memory with busy high; configuration writes are taken during that time. A successful
// allocation first reduces the scan pointer modulo the byte count of the configured frames
// in the shared add/subtract unit, one restoring step per bit, and then reads and checks the
// bitmap bytes in turn (ST_READ, ST_CHECK) on the bitmap memory, which has one read port and
// one write port. An allocation that finds no clear frame scans every byte in use before it
// answers. An allocation with no frames configured answers from the dispatch state without a
// scan. A free compares its page with the regions one after another. The result word is
// shown on rsp_data with rsp_strobe high for exactly one cycle and cannot be held off; busy
// is low in that cycle, so the next word may be started at once.
module region_bitmap_page_allocator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  rbpa_pkg::req_type                    req_data,
   output logic                                 busy,
   output logic                                 rsp_strobe,
   output rbpa_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write,
   input  logic [rbpa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rbpa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rbpa_pkg::*;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_DISPATCH = 4'd2;
   localparam logic [3:0] ST_MOD      = 4'd3;
   localparam logic [3:0] ST_READ     = 4'd4;
   localparam logic [3:0] ST_CHECK    = 4'd5;
   localparam logic [3:0] ST_SELECT   = 4'd6;
   localparam logic [3:0] ST_ADDR     = 4'd7;
   localparam logic [3:0] ST_FCMP     = 4'd8;
   localparam logic [3:0] ST_FREAD    = 4'd9;
   localparam logic [3:0] ST_FWRITE   = 4'd10;

   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(MAP_BYTES - 1);

   // Configuration registers
   logic [1:0]         count_ff;
   logic [BASE_W-1:0]  base_ff  [NUM_REGIONS];
   logic [PAGES_W-1:0] pages_ff [NUM_REGIONS];

   // Sequencer state
   logic [3:0]            state_ff, state_in;
   logic                  op_ff, op_in;
   logic [BASE_W-1:0]     page_ff, page_in;
   layout_type            lay_ff, lay_in;
   logic [BYTE_IDX_W-1:0] sp_ff, sp_in;
   logic [BYTE_CNT_W-1:0] rem_ff, rem_in;
   logic [3:0]            bitcnt_ff, bitcnt_in;
   logic [BYTE_IDX_W-1:0] byte_ff, byte_in;
   logic [BYTE_CNT_W-1:0] k_ff, k_in;
   logic [1:0]            region_ff, region_in;
   logic [FRAME_W-1:0]    idx_ff, idx_in;
   logic [PAGES_W-1:0]    offset_ff, offset_in;
   logic [BASE_W-1:0]     bsel_ff, bsel_in;
   logic [BYTE_IDX_W-1:0] clr_ff, clr_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;

   // Bitmap memory
   logic [7:0]            map_mem [MAP_BYTES];
   logic [7:0]            mem_rdata_ff;
   logic                  mem_we;
   logic [BYTE_IDX_W-1:0] mem_waddr;
   logic [BYTE_IDX_W-1:0] mem_raddr;
   logic [7:0]            mem_wdata;

   // Shared add/subtract unit
   logic [BASE_W:0] alu_a, alu_b, alu_sum;
   logic            alu_sub;

   logic [BYTE_CNT_W-1:0] nbytes;
   logic [BYTE_CNT_W-1:0] trial;
   logic [BYTE_CNT_W-1:0] byte_next;
   logic [7:0]            avail_mask;
   logic [7:0]            free_bits;
   logic [2:0]            free_pos;
   logic [PAGES_W-1:0]    eff_r;
   logic [PAGES_W-1:0]    start_r;
   logic [PAGES_W-1:0]    idx_ext;
   logic [PAGES_W-1:0]    free_idx;
   logic                  free_match;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign nbytes    = BYTE_CNT_W'((14'(lay_ff.total) + 14'd7) >> 3);
   assign trial     = {rem_ff[BYTE_IDX_W-1:0], sp_ff[bitcnt_ff]};
   assign byte_next = {1'b0, byte_ff} + BYTE_CNT_W'(1);
   assign idx_ext   = {1'b0, idx_ff};

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_MOD: begin
            alu_a   = (BASE_W+1)'(trial);
            alu_b   = (BASE_W+1)'(nbytes);
            alu_sub = 1'b1;
         end
         ST_FCMP: begin
            alu_a   = {1'b0, page_ff};
            alu_b   = {1'b0, base_ff[region_ff]};
            alu_sub = 1'b1;
         end
         ST_ADDR: begin
            alu_a = {1'b0, bsel_ff};
            alu_b = (BASE_W+1)'(offset_ff);
         end
         default: begin
            alu_a = '0;
         end
      endcase
      alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + (BASE_W+1)'(alu_sub);
   end

   // Lowest clear bit of the fetched byte that still lies below the total frame count.
   always_comb begin
      if ({1'b0, byte_ff} < lay_ff.total[PAGES_W-1:3]) begin
         avail_mask = 8'hFF;
      end else begin
         avail_mask = (8'd1 << lay_ff.total[2:0]) - 8'd1;
      end
      free_bits = ~mem_rdata_ff & avail_mask;
      free_pos  = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_pos = 3'(i);
         end
      end
   end

   always_comb begin
      case (region_ff)
         2'd0: begin
            eff_r   = lay_ff.eff0;
            start_r = '0;
         end
         2'd1: begin
            eff_r   = lay_ff.eff1;
            start_r = lay_ff.end0;
         end
         default: begin
            eff_r   = lay_ff.eff2;
            start_r = lay_ff.end1;
         end
      endcase
      free_match = !alu_sum[BASE_W] && (alu_sum[BASE_W-1:PAGES_W] == '0)
                   && (alu_sum[PAGES_W-1:0] < eff_r);
      free_idx   = start_r + alu_sum[PAGES_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      page_in       = page_ff;
      lay_in        = lay_ff;
      sp_in         = sp_ff;
      rem_in        = rem_ff;
      bitcnt_in     = bitcnt_ff;
      byte_in       = byte_ff;
      k_in          = k_ff;
      region_in     = region_ff;
      idx_in        = idx_ff;
      offset_in     = offset_ff;
      bsel_in       = bsel_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = byte_ff;
      mem_wdata     = mem_rdata_ff;
      mem_raddr     = (state_ff == ST_FREAD) ? idx_ff[FRAME_W-1:3] : byte_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'h00;
            clr_in    = clr_ff + BYTE_IDX_W'(1);
            if (clr_ff == LAST_BYTE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in    = req_data.op;
               page_in  = req_data.page_address[ADDR_W-1:PAGE_SHIFT];
               lay_in   = calc_layout(count_ff, pages_ff[0], pages_ff[1], pages_ff[2]);
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (op_ff == OP_FREE) begin
               region_in = 2'd0;
               state_in  = ST_FCMP;
            end else if (nbytes == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{frame_address: '0, status: STATUS_NO_FREE};
               state_in      = ST_IDLE;
            end else begin
               rem_in    = '0;
               bitcnt_in = 4'(BYTE_IDX_W - 1);
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            // One restoring step of scan_pointer mod byte count per cycle, MSB first.
            rem_in = alu_sum[BASE_W] ? trial : alu_sum[BYTE_CNT_W-1:0];
            if (bitcnt_ff == 4'd0) begin
               byte_in  = rem_in[BYTE_IDX_W-1:0];
               k_in     = '0;
               state_in = ST_READ;
            end else begin
               bitcnt_in = bitcnt_ff - 4'd1;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (free_bits != 8'h00) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata_ff | (8'd1 << free_pos);
               sp_in     = byte_ff;
               idx_in    = {byte_ff, free_pos};
               state_in  = ST_SELECT;
            end else if (k_ff + BYTE_CNT_W'(1) == nbytes) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{frame_address: '0, status: STATUS_NO_FREE};
               state_in      = ST_IDLE;
            end else begin
               k_in     = k_ff + BYTE_CNT_W'(1);
               byte_in  = (byte_next == nbytes) ? '0 : byte_next[BYTE_IDX_W-1:0];
               state_in = ST_READ;
            end
         end
         ST_SELECT: begin
            if (idx_ext < lay_ff.end0) begin
               offset_in = idx_ext;
               bsel_in   = base_ff[0];
            end else if (idx_ext < lay_ff.end1) begin
               offset_in = idx_ext - lay_ff.end0;
               bsel_in   = base_ff[1];
            end else begin
               offset_in = idx_ext - lay_ff.end1;
               bsel_in   = base_ff[2];
            end
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '{frame_address: {alu_sum[BASE_W-1:0], PAGE_SHIFT'(0)},
                              status: STATUS_OK};
            state_in      = ST_IDLE;
         end
         ST_FCMP: begin
            if (free_match) begin
               idx_in   = free_idx[FRAME_W-1:0];
               state_in = ST_FREAD;
            end else if (region_ff == 2'(NUM_REGIONS - 1)) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{frame_address: '0, status: STATUS_NO_REGION};
               state_in      = ST_IDLE;
            end else begin
               region_in = region_ff + 2'd1;
            end
         end
         ST_FREAD: begin
            state_in = ST_FWRITE;
         end
         ST_FWRITE: begin
            mem_we        = 1'b1;
            mem_waddr     = idx_ff[FRAME_W-1:3];
            mem_wdata     = mem_rdata_ff & ~(8'd1 << idx_ff[2:0]);
            rsp_strobe_in = 1'b1;
            rsp_in        = '{frame_address: '0, status: STATUS_OK};
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= map_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int r = 0; r < NUM_REGIONS; r++) begin
            base_ff[r]  <= '0;
            pages_ff[r] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            CSR_REGION_COUNT: count_ff    <= csr_wdata[1:0];
            CSR_R0_BASE:      base_ff[0]  <= csr_wdata[BASE_W-1:0];
            CSR_R0_PAGES:     pages_ff[0] <= csr_wdata[PAGES_W-1:0];
            CSR_R1_BASE:      base_ff[1]  <= csr_wdata[BASE_W-1:0];
            CSR_R1_PAGES:     pages_ff[1] <= csr_wdata[PAGES_W-1:0];
            CSR_R2_BASE:      base_ff[2]  <= csr_wdata[BASE_W-1:0];
            CSR_R2_PAGES:     pages_ff[2] <= csr_wdata[PAGES_W-1:0];
            default: begin
               count_ff <= count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         sp_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         sp_ff         <= sp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      page_ff   <= page_in;
      lay_ff    <= lay_in;
      rem_ff    <= rem_in;
      bitcnt_ff <= bitcnt_in;
      byte_ff   <= byte_in;
      k_ff      <= k_in;
      region_ff <= region_in;
      idx_ff    <= idx_in;
      offset_ff <= offset_in;
      bsel_ff   <= bsel_in;
      rsp_ff    <= rsp_in;
   end

endmodule

### hdl/rbpa_checker.sv
// Port-level checks of the page frame allocator and the bind that attaches them.
module rbpa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_strobe,
   input rbpa_pkg::rsp_type                 rsp_data
);
   import rbpa_pkg::*;

   // Reset always starts the bitmap clearing pass.
   a_reset_clears : assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   // A started word keeps the block busy for at least the next cycle.
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block idle right after a word was taken");

   // A result word is given as the block returns to idle.
   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result word while busy");

   // Results never come in two consecutive cycles.
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result word repeated");

   // Only a successful result carries a nonzero address.
   a_rsp_addr : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != STATUS_OK) |-> (rsp_data.frame_address == '0))
      else $error("failed result word with nonzero address");

endmodule

bind region_bitmap_page_allocator_core rbpa_checker u_rbpa_checker (.*);
